// ===== rtl/core/ffca_pkg.sv =====
package ffca_pkg;

  // Default sizing of the heap and of each chunk table.
  localparam int HEAP_BYTES_DEF  = 65536;
  localparam int TABLE_DEPTH_DEF = 64;

  // Widths of the request and response fields.
  localparam int OP_W     = 1;
  localparam int REQ_W    = 17;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } ffca_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } ffca_state_t;

endpackage

// ===== rtl/core/ffca_req_if.sv =====
interface ffca_req_if import ffca_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, operation, request_size, address, input ready);
  modport sink (input valid, operation, request_size, address, output ready);
endinterface

// ===== rtl/core/ffca_rsp_if.sv =====
interface ffca_rsp_if import ffca_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   chunk_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, chunk_address, status, input ready);
  modport sink (input valid, chunk_address, status, output ready);
endinterface

// ===== rtl/core/ffca_cell.sv =====
module ffca_cell import ffca_pkg::*; #(
  parameter int            AW        = 16,
  parameter int            SW        = 17,
  parameter bit            RST_VALID = 1'b0,
  parameter logic [SW-1:0] RST_SIZE  = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          in_valid,
  input  logic [AW-1:0] in_start,
  input  logic [SW-1:0] in_size,
  output logic          valid,
  output logic [AW-1:0] start,
  output logic [SW-1:0] size
);

  // One table entry; it takes its neighbor's entry whenever the row shifts.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= RST_VALID;
      start <= '0;
      size  <= RST_SIZE;
    end else if (shift) begin
      valid <= in_valid;
      start <= in_start;
      size  <= in_size;
    end
  end

endmodule

// ===== rtl/core/first_fit_chunk_allocator_unit.sv =====
// First-fit chunk allocator.
// Requests arrive on the req channel: operation 0 allocates request_size
// bytes, operation 1 frees the chunk that starts at address. Each request
// gives exactly one response on the rsp channel with the chunk offset (zero
// unless an allocate succeeds) and a status: ok, no fit or zero size,
// offset not allocated, or table full.
// Free and allocated chunks live in two rows of TABLE_DEPTH cells that
// rotate one position per cycle, while a search or rewrite runs, past a
// head cell watched by the controller. A request takes one full rotation
// to search, a decide step and, if the tables change, a second rotation to
// rewrite them. One request is handled at a time.
// Reset leaves one free chunk covering the whole heap and no allocations;
// no clearing pass is needed. A response waits in an output register while
// the receiver stalls, and the next request is taken once it is loaded.
module first_fit_chunk_allocator_unit import ffca_pkg::*; #(
  parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int CW = (SW > REQ_W) ? SW : REQ_W;
  localparam int MW = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [NW-1:0] FULL = NW'(TABLE_DEPTH);

  ffca_state_t state, state_next;

  logic [IW-1:0]     cnt;
  logic [OP_W-1:0]   op_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic              found;
  logic [AW-1:0]     best_start;
  logic [SW-1:0]     best_size;
  logic              placed;
  logic [NW-1:0]     free_cnt;
  logic [NW-1:0]     used_cnt;
  ffca_status_t      res_status;
  logic              rsp_valid;
  logic [ADDR_W-1:0] rsp_addr;
  ffca_status_t      rsp_status;

  logic          f_valid [TABLE_DEPTH];
  logic [AW-1:0] f_start [TABLE_DEPTH];
  logic [SW-1:0] f_size  [TABLE_DEPTH];
  logic          u_valid [TABLE_DEPTH];
  logic [AW-1:0] u_start [TABLE_DEPTH];
  logic [SW-1:0] u_size  [TABLE_DEPTH];

  logic          shift;
  logic          ff_valid, uf_valid;
  logic [AW-1:0] ff_start, uf_start;
  logic [SW-1:0] ff_size, uf_size;
  logic          place_now;

  logic          fit, better, hit, dec_ok;
  ffca_status_t  dec_status;
  logic [SW-1:0] tail;

  // Two rows of cells, each rotating toward the head at index zero.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
    logic          fn_valid, un_valid;
    logic [AW-1:0] fn_start, un_start;
    logic [SW-1:0] fn_size, un_size;

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign fn_valid = ff_valid;
      assign fn_start = ff_start;
      assign fn_size  = ff_size;
      assign un_valid = uf_valid;
      assign un_start = uf_start;
      assign un_size  = uf_size;
    end else begin : g_mid
      assign fn_valid = f_valid[i+1];
      assign fn_start = f_start[i+1];
      assign fn_size  = f_size[i+1];
      assign un_valid = u_valid[i+1];
      assign un_start = u_start[i+1];
      assign un_size  = u_size[i+1];
    end

    ffca_cell #(
      .AW(AW), .SW(SW), .RST_VALID(i == 0),
      .RST_SIZE((i == 0) ? SW'(HEAP_BYTES) : SW'(0))
    ) u_free (
      .clk(clk), .rst(rst), .shift(shift),
      .in_valid(fn_valid), .in_start(fn_start), .in_size(fn_size),
      .valid(f_valid[i]), .start(f_start[i]), .size(f_size[i])
    );

    ffca_cell #(
      .AW(AW), .SW(SW), .RST_VALID(1'b0), .RST_SIZE(SW'(0))
    ) u_used (
      .clk(clk), .rst(rst), .shift(shift),
      .in_valid(un_valid), .in_start(un_start), .in_size(un_size),
      .valid(u_valid[i]), .start(u_start[i]), .size(u_size[i])
    );
  end

  // Comparisons on the head entries and the decision after the search.
  assign fit    = f_valid[0] && (CW'(f_size[0]) >= CW'(req_q));
  assign better = !found || (f_start[0] < best_start);
  assign hit    = u_valid[0] && (MW'(u_start[0]) == MW'(addr_q));
  assign tail   = best_size - SW'(req_q);

  always_comb begin
    dec_ok     = 1'b0;
    dec_status = ST_OK;
    if (op_q == OP_ALLOC) begin
      if (req_q == '0 || !found) begin
        dec_status = ST_NOFIT;
      end else if (used_cnt == FULL) begin
        dec_status = ST_FULL;
      end else begin
        dec_ok = 1'b1;
      end
    end else begin
      if (!found) begin
        dec_status = ST_UNKNOWN;
      end else if (free_cnt == FULL) begin
        dec_status = ST_FULL;
      end else begin
        dec_ok = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req.valid) state_next = S_SCAN;
      S_SCAN:   if (cnt == LAST) state_next = S_DECIDE;
      S_DECIDE: state_next = dec_ok ? S_UPDATE : S_DONE;
      S_UPDATE: if (cnt == LAST) state_next = S_DONE;
      S_DONE:   if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Row control and the entries fed back into the tail cells.
  always_comb begin
    shift     = (state == S_SCAN) || (state == S_UPDATE);
    ff_valid  = f_valid[0];
    ff_start  = f_start[0];
    ff_size   = f_size[0];
    uf_valid  = u_valid[0];
    uf_start  = u_start[0];
    uf_size   = u_size[0];
    place_now = 1'b0;
    if (state == S_UPDATE) begin
      if (op_q == OP_ALLOC) begin
        // Shrink the chosen free chunk to its tail and record the allocation.
        if (f_valid[0] && f_start[0] == best_start) begin
          ff_valid = (tail != '0);
          ff_start = best_start + AW'(req_q);
          ff_size  = tail;
        end
        if (!u_valid[0] && !placed) begin
          uf_valid  = 1'b1;
          uf_start  = best_start;
          uf_size   = SW'(req_q);
          place_now = 1'b1;
        end
      end else begin
        // Drop the allocation and return its chunk to an empty free slot.
        if (u_valid[0] && u_start[0] == best_start) begin
          uf_valid = 1'b0;
        end
        if (!f_valid[0] && !placed) begin
          ff_valid  = 1'b1;
          ff_start  = best_start;
          ff_size   = best_size;
          place_now = 1'b1;
        end
      end
    end
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      found     <= 1'b0;
      placed    <= 1'b0;
      free_cnt  <= NW'(1);
      used_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != S_DONE && rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q   <= req.operation;
            req_q  <= req.request_size;
            addr_q <= req.address;
            found  <= 1'b0;
            placed <= 1'b0;
            cnt    <= '0;
          end
        end
        S_SCAN: begin
          cnt <= (cnt == LAST) ? '0 : cnt + IW'(1);
          if (op_q == OP_ALLOC) begin
            if (fit && better) begin
              found      <= 1'b1;
              best_start <= f_start[0];
              best_size  <= f_size[0];
            end
          end else if (hit) begin
            found      <= 1'b1;
            best_start <= u_start[0];
            best_size  <= u_size[0];
          end
        end
        S_DECIDE: begin
          res_status <= dec_status;
          if (dec_ok) begin
            if (op_q == OP_ALLOC) begin
              used_cnt <= used_cnt + NW'(1);
              if (tail == '0) free_cnt <= free_cnt - NW'(1);
            end else begin
              free_cnt <= free_cnt + NW'(1);
              used_cnt <= used_cnt - NW'(1);
            end
          end
        end
        S_UPDATE: begin
          cnt <= (cnt == LAST) ? '0 : cnt + IW'(1);
          if (place_now) placed <= 1'b1;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_addr   <= (op_q == OP_ALLOC && res_status == ST_OK) ?
                          ADDR_W'(best_start) : '0;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.chunk_address = rsp_addr;
  assign rsp.status        = rsp_status;

  // Neither table count may exceed the number of cells.
  a_counts: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= FULL && used_cnt <= FULL)
    else $error("chunk table count out of range");

  // A rewrite pass always finds an empty slot for the inserted entry.
  a_placed: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && $past(state) == S_UPDATE) |-> placed)
    else $error("inserted entry found no empty slot");

  // A valid free entry never holds an empty chunk.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    f_valid[0] |-> f_size[0] != '0)
    else $error("free entry with zero size");

endmodule
